// ----- design/spa_pkg.sv -----
`default_nettype none

package spa_pkg;

   // Fixed field widths of a transaction
   localparam int SLOT_INDEX_W = 8;
   localparam int STATUS_W     = 2;
   localparam int GRANT_W      = 4;

   // Default pool size
   localparam int POOL_SLOTS_DEFAULT = 16;

   // Request kinds
   localparam logic KIND_ALLOC   = 1'b0;
   localparam logic KIND_RELEASE = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK           = 2'd0,
      ST_NO_FREE      = 2'd1,
      ST_RANGE        = 2'd2,
      ST_ALREADY_FREE = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE = 2'd0,
      S_EXEC = 2'd1,
      S_SCAN = 2'd2
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic capture;    // latch the incoming request
      logic execute;    // apply the request and load the response register
      logic scan_step;  // examine one slot of the free search
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic grant;      // latched request is an allocate that will succeed
      logic out_busy;   // response register holds a result not yet taken
      logic scan_hit;   // slot under the scan pointer is free
      logic scan_last;  // scan pointer is on the last candidate slot
   } stat_type;

endpackage

`default_nettype wire

// ----- design/spa_if.sv -----
`default_nettype none

interface spa_req_if;
   logic                             valid;
   logic                             ready;
   logic                             kind;
   logic [spa_pkg::SLOT_INDEX_W-1:0] slot_index;

   modport source (output valid, output kind, output slot_index, input ready);
   modport sink   (input valid, input kind, input slot_index, output ready);
endinterface

interface spa_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [spa_pkg::STATUS_W-1:0] status;
   logic [spa_pkg::GRANT_W-1:0]  granted_slot;

   modport source (output valid, output status, output granted_slot, input ready);
   modport sink   (input valid, input status, input granted_slot, output ready);
endinterface

`default_nettype wire

// ----- design/spa_ctrl.sv -----
`default_nettype none

module spa_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire spa_pkg::stat_type stat,
   output spa_pkg::cmd_type       cmd
);

   spa_pkg::state_type state_ff;
   spa_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= spa_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      case (state_ff)
         spa_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = spa_pkg::S_EXEC;
            end
         end
         spa_pkg::S_EXEC: begin
            // hold until the response register can take the result
            if (!stat.out_busy) begin
               cmd.execute = 1'b1;
               state_in    = stat.grant ? spa_pkg::S_SCAN : spa_pkg::S_IDLE;
            end
         end
         spa_pkg::S_SCAN: begin
            cmd.scan_step = 1'b1;
            if (stat.scan_hit || stat.scan_last) begin
               state_in = spa_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = spa_pkg::S_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// ----- design/spa_datapath.sv -----
`default_nettype none

module spa_datapath #(
   parameter int POOL_SLOTS = spa_pkg::POOL_SLOTS_DEFAULT
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire spa_pkg::cmd_type                 cmd,
   output spa_pkg::stat_type                     stat,
   input  wire logic                             req_kind,
   input  wire logic [spa_pkg::SLOT_INDEX_W-1:0] req_slot_index,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output logic [spa_pkg::STATUS_W-1:0]          rsp_status,
   output logic [spa_pkg::GRANT_W-1:0]           rsp_granted_slot
);

   localparam int IDX_W = $clog2(POOL_SLOTS);
   localparam logic [spa_pkg::SLOT_INDEX_W:0] POOL_LIMIT = (spa_pkg::SLOT_INDEX_W+1)'(POOL_SLOTS);
   localparam logic [IDX_W:0]   PTR_LIMIT = (IDX_W+1)'(POOL_SLOTS);
   localparam logic [IDX_W-1:0] SCAN_LAST = IDX_W'(POOL_SLOTS - 1);

   logic [POOL_SLOTS-1:0] free_map_ff, free_map_in;
   logic [IDX_W-1:0]      next_free_ff, next_free_in;
   logic                  pool_full_ff, pool_full_in;
   logic [IDX_W-1:0]      scan_ptr_ff, scan_ptr_in;
   logic [IDX_W-1:0]      scan_cnt_ff, scan_cnt_in;
   logic                  kind_ff, kind_in;
   logic [spa_pkg::SLOT_INDEX_W-1:0] idx_ff, idx_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   spa_pkg::status_type   rsp_status_ff, rsp_status_in;
   logic [spa_pkg::GRANT_W-1:0] rsp_slot_ff, rsp_slot_in;

   logic                  alloc_ok;
   logic                  in_range;
   logic [IDX_W-1:0]      idx_sel;
   logic [IDX_W-1:0]      next_after;
   logic [IDX_W-1:0]      scan_after;
   logic [spa_pkg::SLOT_INDEX_W-1:0] grant_wide;

   // wrapping increment of a slot pointer
   function automatic logic [IDX_W-1:0] ptr_inc(input logic [IDX_W-1:0] ptr);
      logic [IDX_W:0] sum;
      sum = {1'b0, ptr} + (IDX_W+1)'(1);
      return (sum == PTR_LIMIT) ? '0 : sum[IDX_W-1:0];
   endfunction

   assign alloc_ok   = !pool_full_ff && free_map_ff[next_free_ff];
   assign in_range   = {1'b0, idx_ff} < POOL_LIMIT;
   assign idx_sel    = idx_ff[IDX_W-1:0];
   assign next_after = ptr_inc(next_free_ff);
   assign scan_after = ptr_inc(scan_ptr_ff);
   assign grant_wide = spa_pkg::SLOT_INDEX_W'(next_free_ff);

   assign stat.grant     = (kind_ff == spa_pkg::KIND_ALLOC) && alloc_ok;
   assign stat.out_busy  = rsp_valid_ff && !rsp_ready;
   assign stat.scan_hit  = free_map_ff[scan_ptr_ff];
   assign stat.scan_last = (scan_cnt_ff == SCAN_LAST);

   always_comb begin
      free_map_in   = free_map_ff;
      next_free_in  = next_free_ff;
      pool_full_in  = pool_full_ff;
      scan_ptr_in   = scan_ptr_ff;
      scan_cnt_in   = scan_cnt_ff;
      kind_in       = kind_ff;
      idx_in        = idx_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;

      if (cmd.capture) begin
         kind_in = req_kind;
         idx_in  = req_slot_index;
      end

      if (cmd.execute) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = spa_pkg::ST_OK;
         rsp_slot_in   = '0;
         if (kind_ff == spa_pkg::KIND_ALLOC) begin
            if (alloc_ok) begin
               free_map_in[next_free_ff] = 1'b0;
               rsp_slot_in = grant_wide[spa_pkg::GRANT_W-1:0];
               scan_ptr_in = next_after;
               scan_cnt_in = IDX_W'(1);
            end else begin
               rsp_status_in = spa_pkg::ST_NO_FREE;
            end
         end else begin
            if (!in_range) begin
               rsp_status_in = spa_pkg::ST_RANGE;
            end else if (free_map_ff[idx_sel]) begin
               rsp_status_in = spa_pkg::ST_ALREADY_FREE;
            end else begin
               free_map_in[idx_sel] = 1'b1;
               if (pool_full_ff) begin
                  next_free_in = idx_sel;
                  pool_full_in = 1'b0;
               end
            end
         end
      end

      // one candidate slot per cycle; pointer stays put when none is found
      if (cmd.scan_step) begin
         if (free_map_ff[scan_ptr_ff]) begin
            next_free_in = scan_ptr_ff;
         end else if (scan_cnt_ff == SCAN_LAST) begin
            pool_full_in = 1'b1;
         end else begin
            scan_ptr_in = scan_after;
            scan_cnt_in = scan_cnt_ff + IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         free_map_ff  <= '1;
         next_free_ff <= '0;
         pool_full_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         free_map_ff  <= free_map_in;
         next_free_ff <= next_free_in;
         pool_full_ff <= pool_full_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_ptr_ff   <= scan_ptr_in;
      scan_cnt_ff   <= scan_cnt_in;
      kind_ff       <= kind_in;
      idx_ff        <= idx_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_granted_slot = rsp_slot_ff;

endmodule

`default_nettype wire

// ----- design/slot_pool_allocator_core.sv -----
// Slot pool allocator: keeps a free bit for each of POOL_SLOTS slots, a pointer to the
// next free slot and a full flag. An allocate transaction (kind 0) grants the slot under
// the pointer and then searches forward, wrapping at the pool end, for the next free
// slot; a release transaction (kind 1) frees an in-use slot and, if the pool was full,
// points at it. Every request yields exactly one response carrying a status (ok, no free
// slot, index out of range, slot already free) and the granted slot, low four bits,
// zero unless an allocate succeeded. Timing: a request is latched on acceptance, then
// the execute step, waiting while an earlier response is untaken, loads the response
// register; after a successful allocate the forward search examines one slot per cycle,
// and the next request is accepted once it finds a free slot or reaches the last
// candidate. That search loop sets the worst-case rate. The response sits in an output
// register, so a new request can be taken while an earlier response waits for rsp ready.
`default_nettype none

module slot_pool_allocator_core #(
   parameter int POOL_SLOTS = spa_pkg::POOL_SLOTS_DEFAULT
) (
   input  wire logic  clock,
   input  wire logic  reset,
   spa_req_if.sink    req_if,
   spa_rsp_if.source  rsp_if
);

   spa_pkg::cmd_type  cmd;
   spa_pkg::stat_type stat;

   // sequencer: accept, execute, then the free-slot search
   spa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // free map, pointer, full flag and response register
   spa_datapath #(
      .POOL_SLOTS (POOL_SLOTS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_kind         (req_if.kind),
      .req_slot_index   (req_if.slot_index),
      .rsp_valid        (rsp_if.valid),
      .rsp_ready        (rsp_if.ready),
      .rsp_status       (rsp_if.status),
      .rsp_granted_slot (rsp_if.granted_slot)
   );

endmodule

`default_nettype wire
